FILE: rtl/block_request_chain_validator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the request chain validator
// Concurrent checks on i_clk, held off while i_rst_n is low. They compile to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BLOCK_REQUEST_CHAIN_VALIDATOR_ASSERT_SVH
`define BLOCK_REQUEST_CHAIN_VALIDATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define BRCV_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("brcv assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BRCV_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("brcv assertion failed");

`else

`define BRCV_ASSERT_IMPL(name, ante, cons)
`define BRCV_ASSERT_NEXT(name, ante, cons)

`endif

`endif

FILE: rtl/brcv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brcv_pkg
// Codes, field widths and the classified descriptor record shared by the
// front, the queue and the back of the request chain validator.
// ----------------------------------------------------------------------------
package brcv_pkg;

    localparam int unsigned LEN_W      = 32;
    localparam int unsigned TYPE_W     = 32;
    localparam int unsigned SECTOR_W   = 64;
    localparam int unsigned HEAD_W     = 16;
    localparam int unsigned COUNT_W    = 32;
    localparam int unsigned SEGCNT_W   = 9;
    localparam int unsigned OUTCOME_W  = 3;
    localparam int unsigned SECT_SHIFT = 9;
    localparam int unsigned LEN_SECT_W = LEN_W - SECT_SHIFT;

    localparam logic [LEN_W-1:0] HDR_BYTES    = 32'd16;
    localparam logic [LEN_W-1:0] STATUS_BYTES = 32'd1;

    localparam logic [TYPE_W-1:0] TYPE_READ  = 32'd0;
    localparam logic [TYPE_W-1:0] TYPE_WRITE = 32'd1;
    localparam logic [TYPE_W-1:0] TYPE_FLUSH = 32'd4;

    localparam logic [OUTCOME_W-1:0] OUT_READ  = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_WRITE = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_FLUSH = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_DROP  = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_BAD   = 3'd4;
    localparam logic [OUTCOME_W-1:0] ERR_NONE  = 3'd0;

    localparam int unsigned FIFO_AW    = 2;
    localparam int unsigned FIFO_DEPTH = 1 << FIFO_AW;

    // One descriptor after classification by the front.
    typedef struct packed {
        logic [LEN_SECT_W-1:0] sectors;
        logic                  data_ok;
        logic                  status_ok;
        logic                  ro;
        logic                  last;
        logic                  hdr_ok;
        logic                  is_flush;
        logic                  is_read;
        logic [SECTOR_W-1:0]   hdr_sector;
        logic [HEAD_W-1:0]     head;
    } t_desc_rec;

endpackage

FILE: rtl/brcv_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brcv_desc_if / brcv_res_if
// Valid/ready channels for incoming descriptors and finished chain results.
// ----------------------------------------------------------------------------
interface brcv_desc_if;
    logic        valid;
    logic        ready;
    logic [31:0] desc_len;
    logic        desc_read_only;
    logic        desc_last;
    logic [31:0] hdr_type;
    logic [63:0] hdr_sector;
    logic [15:0] head_index;

    modport source (
        output valid, desc_len, desc_read_only, desc_last, hdr_type, hdr_sector,
               head_index,
        input  ready
    );
    modport sink (
        input  valid, desc_len, desc_read_only, desc_last, hdr_type, hdr_sector,
               head_index,
        output ready
    );
endinterface

interface brcv_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  outcome;
    logic [63:0] start_sector;
    logic [31:0] sector_count;
    logic [8:0]  segment_count;
    logic [15:0] chain_head;

    modport source (
        output valid, outcome, start_sector, sector_count, segment_count, chain_head,
        input  ready
    );
    modport sink (
        input  valid, outcome, start_sector, sector_count, segment_count, chain_head,
        output ready
    );
endinterface

FILE: rtl/brcv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brcv_front
// Takes descriptors and decodes lengths and request types into a compact
// record that is pushed into the queue.
// ----------------------------------------------------------------------------
module brcv_front
    import brcv_pkg::*;
(
    brcv_desc_if.sink  i_desc,
    input  logic       i_full,
    output logic       o_push,
    output t_desc_rec  o_rec
);

    logic type_read;
    logic type_write;
    logic type_flush;

    assign i_desc.ready = !i_full;
    assign o_push       = i_desc.valid && !i_full;

    assign type_read  = (i_desc.hdr_type == TYPE_READ);
    assign type_write = (i_desc.hdr_type == TYPE_WRITE);
    assign type_flush = (i_desc.hdr_type == TYPE_FLUSH);

    always_comb begin
        o_rec.sectors    = i_desc.desc_len[LEN_W-1:SECT_SHIFT];
        // Nonzero and a whole number of sectors.
        o_rec.data_ok    = (i_desc.desc_len[LEN_W-1:SECT_SHIFT] != '0)
                        && (i_desc.desc_len[SECT_SHIFT-1:0] == '0);
        o_rec.status_ok  = (i_desc.desc_len == STATUS_BYTES);
        o_rec.ro         = i_desc.desc_read_only;
        o_rec.last       = i_desc.desc_last;
        o_rec.hdr_ok     = (i_desc.desc_len == HDR_BYTES)
                        && (type_read || type_write || type_flush);
        o_rec.is_flush   = type_flush;
        o_rec.is_read    = type_read;
        o_rec.hdr_sector = i_desc.hdr_sector;
        o_rec.head       = i_desc.head_index;
    end

endmodule

FILE: rtl/brcv_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brcv_fifo
// Short show-ahead queue of classified descriptors between front and back.
// ----------------------------------------------------------------------------
`include "block_request_chain_validator_assert.svh"

module brcv_fifo
    import brcv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_desc_rec i_push_data,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_valid,
    output t_desc_rec o_data
);

    t_desc_rec              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     r_wr_ptr;
    logic [FIFO_AW-1:0]     r_rd_ptr;
    logic [FIFO_AW:0]       r_count;

    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (FIFO_AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (FIFO_AW+1)'(1);
            end
        end
    end

    `BRCV_ASSERT_IMPL(a_fifo_no_overflow, o_full, !i_push)
    `BRCV_ASSERT_IMPL(a_fifo_no_underflow, !o_valid, !i_pop)
    `BRCV_ASSERT_NEXT(a_fifo_push_fills, i_push, o_valid)

endmodule

FILE: rtl/brcv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brcv_back
// Chain state machine: applies header, data and status checks to queued
// descriptors and registers one result per chain.
// ----------------------------------------------------------------------------
`include "block_request_chain_validator_assert.svh"

module brcv_back
    import brcv_pkg::*;
#(
    parameter int unsigned MAX_SEGMENTS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [SECTOR_W-1:0] i_cap,
    input  logic                i_valid,
    input  t_desc_rec           i_rec,
    output logic                o_pop,
    brcv_res_if.source          o_res
);

    localparam int unsigned SEG_W = $clog2(MAX_SEGMENTS + 1);

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_DATA   = 3'b010,
        PH_SKIP   = 3'b100
    } t_phase;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_FLUSH = 2'd2
    } t_kind;

    t_phase                r_phase, n_phase;
    t_kind                 r_kind, n_kind;
    logic [SECTOR_W-1:0]   r_saved, n_saved;
    logic [COUNT_W-1:0]    r_running, n_running;
    logic [SEG_W-1:0]      r_segs, n_segs;
    logic [OUTCOME_W-1:0]  r_err, n_err;
    logic [HEAD_W-1:0]     r_head, n_head;
    logic [SECTOR_W-1:0]   r_room, n_room;

    logic                  r_out_valid;
    logic [OUTCOME_W-1:0]  r_out_outcome;
    logic [SECTOR_W-1:0]   r_out_sector;
    logic [COUNT_W-1:0]    r_out_count;
    logic [SEGCNT_W-1:0]   r_out_segs;
    logic [HEAD_W-1:0]     r_out_head;

    logic                  out_free;
    logic                  hdr_pop;
    logic [SECTOR_W-1:0]   room_base;
    logic [COUNT_W:0]      total;
    logic                  data_bad;
    logic                  emit;
    logic [OUTCOME_W-1:0]  emit_outcome;
    logic                  emit_drop;
    logic [SEG_W+SEGCNT_W-1:0] segs_wide;

    // A descriptor that ends no chain moves on even while a result waits.
    assign out_free = !r_out_valid || o_res.ready;
    assign o_pop    = i_valid && (!i_rec.last || out_free);
    assign hdr_pop  = o_pop && (r_phase == PH_HEADER);

    // Room left on the device past the start sector; a header loads it at once.
    assign room_base = hdr_pop ? i_rec.hdr_sector : r_saved;
    assign n_room    = i_cap - room_base;

    assign total = {1'b0, r_running} + (COUNT_W+1)'(i_rec.sectors);

    assign data_bad = !i_rec.data_ok
                   || ((r_kind == KIND_READ) && i_rec.ro)
                   || total[COUNT_W]
                   || ({{(SECTOR_W-COUNT_W-1){1'b0}}, total} > r_room)
                   || (r_segs >= SEG_W'(MAX_SEGMENTS));

    always_comb begin
        n_phase      = r_phase;
        n_kind       = r_kind;
        n_saved      = r_saved;
        n_running    = r_running;
        n_segs       = r_segs;
        n_err        = r_err;
        n_head       = r_head;
        emit         = 1'b0;
        emit_outcome = OUT_BAD;
        if (o_pop) begin
            case (r_phase)
                PH_HEADER: begin
                    n_saved   = i_rec.hdr_sector;
                    n_head    = i_rec.head;
                    n_running = '0;
                    n_segs    = '0;
                    n_err     = ERR_NONE;
                    n_kind    = KIND_READ;
                    if (!i_rec.hdr_ok) begin
                        n_err   = OUT_DROP;
                        n_phase = PH_SKIP;
                    end else if (i_rec.is_flush) begin
                        n_kind  = KIND_FLUSH;
                        n_phase = PH_SKIP;
                    end else begin
                        n_kind = i_rec.is_read ? KIND_READ : KIND_WRITE;
                        if (i_rec.hdr_sector >= i_cap) begin
                            n_err   = OUT_BAD;
                            n_phase = PH_SKIP;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                    if (i_rec.last) begin
                        emit    = 1'b1;
                        n_phase = PH_HEADER;
                        if (n_err != ERR_NONE) begin
                            emit_outcome = n_err;
                        end else if (n_kind == KIND_FLUSH) begin
                            emit_outcome = OUT_FLUSH;
                        end else begin
                            emit_outcome = OUT_BAD;
                        end
                    end
                end
                PH_DATA: begin
                    if (i_rec.last) begin
                        emit    = 1'b1;
                        n_phase = PH_HEADER;
                        if (!i_rec.status_ok || i_rec.ro || (r_running == '0)) begin
                            emit_outcome = OUT_BAD;
                        end else begin
                            emit_outcome = {1'b0, r_kind};
                        end
                    end else if (data_bad) begin
                        n_err   = OUT_BAD;
                        n_phase = PH_SKIP;
                    end else begin
                        n_running = total[COUNT_W-1:0];
                        n_segs    = r_segs + SEG_W'(1);
                    end
                end
                PH_SKIP: begin
                    if (i_rec.last) begin
                        emit         = 1'b1;
                        n_phase      = PH_HEADER;
                        emit_outcome = (r_err != ERR_NONE) ? r_err : OUT_FLUSH;
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
        end
    end

    assign emit_drop = (emit_outcome == OUT_DROP);
    assign segs_wide = {{SEGCNT_W{1'b0}}, n_segs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_kind    <= KIND_READ;
            r_running <= '0;
            r_segs    <= '0;
            r_err     <= ERR_NONE;
        end else begin
            r_phase   <= n_phase;
            r_kind    <= n_kind;
            r_running <= n_running;
            r_segs    <= n_segs;
            r_err     <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_saved <= n_saved;
        r_head  <= n_head;
        r_room  <= n_room;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // A dropped header reports no sector range or data totals.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_outcome <= emit_outcome;
            r_out_sector  <= emit_drop ? '0 : n_saved;
            r_out_count   <= emit_drop ? '0 : n_running;
            r_out_segs    <= emit_drop ? '0 : segs_wide[SEGCNT_W-1:0];
            r_out_head    <= n_head;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.outcome       = r_out_outcome;
    assign o_res.start_sector  = r_out_sector;
    assign o_res.sector_count  = r_out_count;
    assign o_res.segment_count = r_out_segs;
    assign o_res.chain_head    = r_out_head;

    `BRCV_ASSERT_NEXT(a_last_gives_result, o_pop && i_rec.last, r_out_valid)
    `BRCV_ASSERT_NEXT(a_mid_chain_stays, o_pop && !i_rec.last, r_phase != PH_HEADER)
    `BRCV_ASSERT_IMPL(a_drop_is_empty, r_out_valid && (r_out_outcome == OUT_DROP), (r_out_sector == '0) && (r_out_count == '0) && (r_out_segs == '0))
    `BRCV_ASSERT_IMPL(a_totals_agree, 1'b1, (r_segs == '0) == (r_running == '0))

endmodule

FILE: rtl/block_request_chain_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_request_chain_validator
// Checks the descriptors of block request chains and reports one result per
// chain: request type, start sector, sector and segment totals, head index.
// ----------------------------------------------------------------------------
//  Port          Dir  Handshake          Carries
//  i_desc        in   valid/ready        one descriptor of a request chain
//  o_res         out  valid/ready        one result per finished chain
//  i_cfg_we/data in   write enable only  device capacity in sectors
//
//  One descriptor per cycle is taken while the queue is not full; the front
//  decodes it in the cycle it arrives and the back handles it from a 4-entry
//  queue, so a result passes through the queue and the result register after
//  the last descriptor. The back checks each descriptor combinationally and
//  takes the next one as the queue shows it. A last descriptor waits in the
//  queue while the result register is full; other descriptors keep flowing.
//  Synchronous reset sets the capacity to one sector.
// ----------------------------------------------------------------------------
module block_request_chain_validator
    import brcv_pkg::*;
#(
    parameter int unsigned MAX_SEGMENTS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    brcv_desc_if.sink           i_desc,
    brcv_res_if.source          o_res,
    input  logic                i_cfg_we,
    input  logic [SECTOR_W-1:0] i_cfg_data
);

    logic [SECTOR_W-1:0] r_capacity;
    logic                push;
    t_desc_rec           push_rec;
    logic                fifo_full;
    logic                fifo_valid;
    t_desc_rec           fifo_rec;
    logic                pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= SECTOR_W'(1);
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_data;
        end
    end

    brcv_front u_front (
        .i_desc (i_desc),
        .i_full (fifo_full),
        .o_push (push),
        .o_rec  (push_rec)
    );

    brcv_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_rec),
        .o_full      (fifo_full),
        .i_pop       (pop),
        .o_valid     (fifo_valid),
        .o_data      (fifo_rec)
    );

    brcv_back #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cap   (r_capacity),
        .i_valid (fifo_valid),
        .i_rec   (fifo_rec),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule
